// ===== rtl/first_fit_block_allocator_top_assert.svh =====
// Assertion macros used by the allocator controller.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffba_pkg.sv =====
// Package with the allocator's constants, codes and controller/datapath types.
`default_nettype none
package ffba_pkg;

    localparam int POOL_BYTES    = 65536;
    localparam int GRANULE_BYTES = 16;
    localparam int HEADER_BYTES  = 16;

    localparam int NGRAN      = POOL_BYTES / GRANULE_BYTES;
    localparam int IDX_W      = $clog2(NGRAN);
    localparam int LEN_W      = IDX_W + 1;
    localparam int GRAN_SHIFT = $clog2(GRANULE_BYTES);
    localparam int MEM_W      = LEN_W + 2;
    localparam int MIN_REST   = (HEADER_BYTES + GRANULE_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;

    localparam int OP_W     = 1;
    localparam int REQ_W    = 20;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = REQ_W + 1;

    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_ZERO,
        ST_NOFIT,
        ST_BADREL
    } status_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_RD_FIRST,
        ACT_RD_IDX,
        ACT_STEP,
        ACT_TAKE,
        ACT_SPLIT,
        ACT_SHRINK,
        ACT_FREE,
        ACT_M_LOOK,
        ACT_M_JOIN,
        ACT_M_CLR,
        ACT_M_ADV
    } act_t;

    typedef struct packed {
        act_t    act;
        logic    push;
        status_t res_status;
        logic    res_grant;
    } ffba_cmd_t;

    typedef struct packed {
        logic op_release;
        logic req_zero;
        logic rel_null;
        logic rel_bad;
        logic rd_len_zero;
        logic rd_free;
        logic rd_start;
        logic fits;
        logic split_ok;
        logic step_out;
        logic clen_out;
        logic clr_done;
        logic slot_free;
    } ffba_sts_t;

endpackage
`default_nettype wire

// ===== rtl/ffba_req_if.sv =====
// Request channel interface: operation, size and release address.
`default_nettype none
interface ffba_req_if;
    import ffba_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [REQ_W-1:0]  req_bytes;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output operation, output req_bytes, output address,
                    input ready);
    modport sink   (input valid, input operation, input req_bytes, input address,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/ffba_rsp_if.sv =====
// Response channel interface: granted offset and status.
`default_nettype none
interface ffba_rsp_if;
    import ffba_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   grant_address;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output grant_address, output status, input ready);
    modport sink   (input valid, input grant_address, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== rtl/ffba_ctrl.sv =====
// Allocator controller: sequences clearing, chain walks, merges and results.
`default_nettype none
`include "first_fit_block_allocator_top_assert.svh"
module ffba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffba_pkg::ffba_sts_t sts,
    output ffba_pkg::ffba_cmd_t cmd
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_CHECK,
        S_A_SHRINK,
        S_R_CHECK,
        S_M_START,
        S_M_CUR,
        S_M_NXT,
        S_M_CLR,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t res_status_reg, res_status_next;
    logic    res_grant_reg, res_grant_next;
    act_t    act;

    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        act             = ACT_NONE;
        case (state_reg)
            S_CLEAR:
            begin
                act = ACT_CLEAR;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act        = ACT_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                res_grant_next = 1'b0;
                if (!sts.op_release)
                begin
                    if (sts.req_zero)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        act        = ACT_RD_FIRST;
                        state_next = S_A_CHECK;
                    end
                end
                else if (sts.rel_null)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_RESULT;
                end
                else if (sts.rel_bad)
                begin
                    res_status_next = ST_BADREL;
                    state_next      = S_RESULT;
                end
                else
                begin
                    act        = ACT_RD_IDX;
                    state_next = S_R_CHECK;
                end
            end
            S_A_CHECK:
            begin
                if (sts.rd_len_zero)
                begin
                    res_status_next = ST_NOFIT;
                    state_next      = S_RESULT;
                end
                else if (sts.fits)
                begin
                    res_status_next = ST_OK;
                    res_grant_next  = 1'b1;
                    if (sts.split_ok)
                    begin
                        act        = ACT_SPLIT;
                        state_next = S_A_SHRINK;
                    end
                    else
                    begin
                        act        = ACT_TAKE;
                        state_next = S_RESULT;
                    end
                end
                else if (sts.step_out)
                begin
                    res_status_next = ST_NOFIT;
                    state_next      = S_RESULT;
                end
                else
                begin
                    act = ACT_STEP;
                end
            end
            S_A_SHRINK:
            begin
                act        = ACT_SHRINK;
                state_next = S_RESULT;
            end
            S_R_CHECK:
            begin
                if (!sts.rd_start)
                begin
                    res_status_next = ST_BADREL;
                    state_next      = S_RESULT;
                end
                else
                begin
                    act             = ACT_FREE;
                    res_status_next = ST_OK;
                    state_next      = S_M_START;
                end
            end
            S_M_START:
            begin
                act        = ACT_RD_FIRST;
                state_next = S_M_CUR;
            end
            S_M_CUR:
            begin
                if (sts.rd_len_zero || sts.step_out)
                begin
                    state_next = S_RESULT;
                end
                else if (sts.rd_free)
                begin
                    act        = ACT_M_LOOK;
                    state_next = S_M_NXT;
                end
                else
                begin
                    act = ACT_STEP;
                end
            end
            S_M_NXT:
            begin
                if (sts.rd_start && sts.rd_free)
                begin
                    act        = ACT_M_JOIN;
                    state_next = S_M_CLR;
                end
                else
                begin
                    act        = ACT_M_ADV;
                    state_next = S_M_CUR;
                end
            end
            S_M_CLR:
            begin
                act = ACT_M_CLR;
                if (sts.clen_out)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_M_NXT;
                end
            end
            S_RESULT:
            begin
                if (sts.slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            res_status_reg <= ST_OK;
            res_grant_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_grant_reg  <= res_grant_next;
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign cmd.act        = act;
    assign cmd.push       = (state_reg == S_RESULT) && sts.slot_free;
    assign cmd.res_status = res_status_reg;
    assign cmd.res_grant  = res_grant_reg;

    `FFBA_ASSERT_NXT(a_accept_decode, in_valid && in_ready, state_reg == S_DECODE, "accepted transaction not decoded")
    `FFBA_ASSERT_NXT(a_result_idle, state_reg == S_RESULT && sts.slot_free, state_reg == S_IDLE, "result pushed without return to idle")
    `FFBA_ASSERT_NXT(a_clear_done, state_reg == S_CLEAR && sts.clr_done, state_reg == S_IDLE, "clearing pass did not end")
endmodule
`default_nettype wire

// ===== rtl/ffba_dp.sv =====
// Allocator datapath: block table RAM, walk pointers and response register.
`default_nettype none
module ffba_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ffba_pkg::OP_W-1:0]     in_operation,
    input  logic [ffba_pkg::REQ_W-1:0]    in_req_bytes,
    input  logic [ffba_pkg::ADDR_W-1:0]   in_address,
    input  ffba_pkg::ffba_cmd_t           cmd,
    output ffba_pkg::ffba_sts_t           sts,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [ffba_pkg::ADDR_W-1:0]   out_grant_address,
    output logic [ffba_pkg::STATUS_W-1:0] out_status
);
    import ffba_pkg::*;

    localparam logic [MEM_W-1:0] INIT_WORD = {LEN_W'(NGRAN), 1'b1, 1'b1};

    logic [OP_W-1:0]     op_reg, op_next;
    logic [SUM_W-1:0]    need_reg, need_next;
    logic                req_zero_reg, req_zero_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0]    clen_reg, clen_next;
    logic [IDX_W-1:0]    nxt_reg, nxt_next;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   out_grant_reg, out_grant_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [MEM_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [MEM_W-1:0] rdata;

    logic [LEN_W-1:0]  rd_len;
    logic              rd_free;
    logic              rd_start;
    logic [SUM_W-1:0]  req_sum;
    logic [LEN_W:0]    step_sum;
    logic [LEN_W:0]    clen_sum;
    logic [SUM_W:0]    split_sum;
    logic [LEN_W-1:0]  rest;
    logic [LEN_W-1:0]  join_len;
    logic [ADDR_W-1:0] rel_off;
    logic [ADDR_W-1:0] rel_gidx;
    logic [IDX_W-1:0]  rel_idx;
    logic [31:0]       grant_full;
    logic              slot_free;

    ffba_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NGRAN)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_len    = rdata[MEM_W-1:2];
    assign rd_free   = rdata[1];
    assign rd_start  = rdata[0];
    assign req_sum   = SUM_W'(in_req_bytes) + SUM_W'(HEADER_BYTES + GRANULE_BYTES - 1);
    assign step_sum  = (LEN_W+1)'(cur_reg) + (LEN_W+1)'(rd_len);
    assign clen_sum  = (LEN_W+1)'(cur_reg) + (LEN_W+1)'(clen_reg);
    assign split_sum = (SUM_W+1)'(cur_reg) + (SUM_W+1)'(need_reg);
    assign rest      = rd_len - LEN_W'(need_reg);
    assign join_len  = clen_reg + rd_len;
    assign rel_off   = addr_reg - ADDR_W'(HEADER_BYTES);
    assign rel_gidx  = rel_off >> GRAN_SHIFT;
    assign rel_idx   = IDX_W'(rel_gidx);
    assign grant_full = (32'(cur_reg) << GRAN_SHIFT) + 32'(HEADER_BYTES);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        op_next       = op_reg;
        need_next     = need_reg;
        req_zero_next = req_zero_reg;
        addr_next     = addr_reg;
        cur_next      = cur_reg;
        clen_next     = clen_reg;
        nxt_next      = nxt_reg;
        clr_cnt_next  = clr_cnt_reg;
        we            = 1'b0;
        waddr         = cur_reg;
        wdata         = '0;
        raddr         = cur_reg;
        case (cmd.act)
            ACT_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wdata        = (clr_cnt_reg == '0) ? INIT_WORD : '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            ACT_LOAD:
            begin
                op_next       = in_operation;
                need_next     = req_sum >> GRAN_SHIFT;
                req_zero_next = (in_req_bytes == '0);
                addr_next     = in_address;
            end
            ACT_RD_FIRST:
            begin
                cur_next = '0;
                raddr    = '0;
            end
            ACT_RD_IDX:
            begin
                cur_next = rel_idx;
                raddr    = rel_idx;
            end
            ACT_STEP:
            begin
                cur_next = step_sum[IDX_W-1:0];
                raddr    = step_sum[IDX_W-1:0];
            end
            ACT_TAKE:
            begin
                we    = 1'b1;
                wdata = {rd_len, 1'b0, 1'b1};
            end
            ACT_SPLIT:
            begin
                we    = 1'b1;
                waddr = split_sum[IDX_W-1:0];
                wdata = {rest, 1'b1, 1'b1};
            end
            ACT_SHRINK:
            begin
                we    = 1'b1;
                wdata = {LEN_W'(need_reg), 1'b0, 1'b1};
            end
            ACT_FREE:
            begin
                we    = 1'b1;
                wdata = {rd_len, 1'b1, 1'b1};
            end
            ACT_M_LOOK:
            begin
                clen_next = rd_len;
                nxt_next  = step_sum[IDX_W-1:0];
                raddr     = step_sum[IDX_W-1:0];
            end
            ACT_M_JOIN:
            begin
                we        = 1'b1;
                wdata     = {join_len, 1'b1, 1'b1};
                clen_next = join_len;
            end
            ACT_M_CLR:
            begin
                we       = 1'b1;
                waddr    = nxt_reg;
                wdata    = '0;
                nxt_next = clen_sum[IDX_W-1:0];
                raddr    = clen_sum[IDX_W-1:0];
            end
            ACT_M_ADV:
            begin
                cur_next = nxt_reg;
                raddr    = nxt_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_grant_next  = out_grant_reg;
        out_status_next = out_status_reg;
        if (cmd.push)
        begin
            out_valid_next  = 1'b1;
            out_grant_next  = cmd.res_grant ? grant_full[ADDR_W-1:0] : '0;
            out_status_next = cmd.res_status;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        need_reg       <= need_next;
        req_zero_reg   <= req_zero_next;
        addr_reg       <= addr_next;
        cur_reg        <= cur_next;
        clen_reg       <= clen_next;
        nxt_reg        <= nxt_next;
        out_grant_reg  <= out_grant_next;
        out_status_reg <= out_status_next;
    end

    assign sts.op_release  = (op_reg == OP_RELEASE);
    assign sts.req_zero    = req_zero_reg;
    assign sts.rel_null    = (addr_reg == '0);
    assign sts.rel_bad     = (addr_reg < ADDR_W'(HEADER_BYTES))
                          || (rel_off[GRAN_SHIFT-1:0] != '0)
                          || (32'(rel_gidx) >= 32'(NGRAN));
    assign sts.rd_len_zero = (rd_len == '0);
    assign sts.rd_free     = rd_free;
    assign sts.rd_start    = rd_start;
    assign sts.fits        = rd_free && (SUM_W'(rd_len) >= need_reg);
    assign sts.split_ok    = (rest >= LEN_W'(MIN_REST)) && (split_sum < (SUM_W+1)'(NGRAN));
    assign sts.step_out    = (step_sum >= (LEN_W+1)'(NGRAN));
    assign sts.clen_out    = (clen_sum >= (LEN_W+1)'(NGRAN));
    assign sts.clr_done    = (clr_cnt_reg == IDX_W'(NGRAN - 1));
    assign sts.slot_free   = slot_free;

    assign out_valid         = out_valid_reg;
    assign out_grant_address = out_grant_reg;
    assign out_status        = out_status_reg;
endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator with coalescing.
//
// Channel  Direction  Carries
// req      in         operation, req_bytes, address
// rsp      out        grant_address, status
//
// After reset a clearing pass writes all 4096 table entries, one a cycle; req is not ready then.
// An allocate walks the chain from block 0 to the first fit and splits off a large enough rest.
// A release checks the block start, frees it, then merges adjacent free blocks from block 0 on.
// The pace is set by the single-read, single-write block table RAM with registered read.
// One transaction is in work at a time; req is ready again once the result enters rsp.
// A result waits in the rsp register while rsp.ready is low; the next request is then taken.
`default_nettype none
module first_fit_block_allocator_top (
    input  logic       clk,
    input  logic       rst_n,
    ffba_req_if.sink   req,
    ffba_rsp_if.source rsp
);
    import ffba_pkg::*;

    ffba_cmd_t cmd;
    ffba_sts_t sts;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_operation      (req.operation),
        .in_req_bytes      (req.req_bytes),
        .in_address        (req.address),
        .cmd               (cmd),
        .sts               (sts),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_grant_address (rsp.grant_address),
        .out_status        (rsp.status)
    );
endmodule
`default_nettype wire
